FILE: hdl/smpt_pkg.sv
`default_nettype none

package smpt_pkg;

  // Coordinate width of the kept pointer, default for the top level
  localparam int COORD_WIDTH_DEF = 16;

  // Entries between the framing front and the motion back end
  localparam int QUEUE_DEPTH = 2;

  // Raw delta: sync format sums two signed bytes and may negate them
  localparam int DELTA_W = 10;
  // Shaped delta: 9-bit magnitude times 8-bit gain, plus sign
  localparam int SHAPED_W = 18;

  localparam int REG_IDX_W = 3;
  localparam int REG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_PROTOCOL = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_MIN_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_MAX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_MIN_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_MAX_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GAP_LIMIT = 3'd6;

  localparam logic signed [15:0] CLIP_MAX_X_RST = 16'sd1024;
  localparam logic signed [15:0] CLIP_MAX_Y_RST = 16'sd768;
  localparam logic [15:0] GAP_LIMIT_RST = 16'd500;

  localparam logic [7:0] MIDDLE_UP_BYTE = 8'h00;
  localparam logic [7:0] MIDDLE_DOWN_BYTE = 8'h20;
  localparam logic [3:0] SYNC_HEAD_NIB = 4'h8;
  localparam logic [3:0] SCROLL_UP_NIB = 4'hf;
  localparam logic [3:0] SCROLL_DOWN_NIB = 4'h1;

  typedef enum logic [1:0] {
    PROTO_THREE = 2'd0,
    PROTO_WHEEL = 2'd1,
    PROTO_SYNC  = 2'd2,
    PROTO_NONE  = 2'd3
  } proto_t;

  typedef struct packed {
    proto_t      protocol;
    logic [15:0] gap_limit_ms;
  } front_cfg_t;

  typedef struct packed {
    logic [7:0]         acceleration;
    logic signed [15:0] clip_min_x;
    logic signed [15:0] clip_max_x;
    logic signed [15:0] clip_min_y;
    logic signed [15:0] clip_max_y;
  } back_cfg_t;

  // One decoded packet. hold: keep the held buttons and replace middle only.
  typedef struct packed {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic [4:0]                buttons;
    logic                      hold;
    logic [31:0]               time_ms;
  } cmd_t;

  // Byte 0 bits 5:4 (left, right) to button bits
  function automatic logic [2:0] three_byte_map(input logic [1:0] idx);
    logic [2:0] r;
    unique case (idx)
      2'd0: r = 3'd0;
      2'd1: r = 3'd4;
      2'd2: r = 3'd1;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] sync_map(input logic [2:0] idx);
    logic [2:0] r;
    unique case (idx)
      3'd0: r = 3'd0;
      3'd1: r = 3'd4;
      3'd2: r = 3'd2;
      3'd3: r = 3'd6;
      3'd4: r = 3'd1;
      3'd5: r = 3'd5;
      3'd6: r = 3'd3;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/smpt_if.sv
`default_nettype none

interface smpt_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [15:0] elapsed_ms;
  logic [31:0] time_ms;

  modport source(output valid, output rx_byte, output elapsed_ms, output time_ms,
                 input ready);
  modport sink(input valid, input rx_byte, input elapsed_ms, input time_ms,
               output ready);
endinterface

interface smpt_event_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [4:0]         button_bits;
  logic [31:0]        event_time;
  logic               buttons_changed;

  modport source(output valid, output pos_x, output pos_y, output button_bits,
                 output event_time, output buttons_changed, input ready);
  modport sink(input valid, input pos_x, input pos_y, input button_bits,
               input event_time, input buttons_changed, output ready);
endinterface

`default_nettype wire

FILE: hdl/smpt_front.sv
`default_nettype none

module smpt_front (
  input  logic                    clk,
  input  logic                    rst,
  input  smpt_pkg::front_cfg_t    cfg,
  input  logic                    proto_wr,
  smpt_byte_if.sink               byte_in,
  input  logic                    q_space,
  output logic                    push,
  output smpt_pkg::cmd_t          cmd
);
  import smpt_pkg::*;

  logic [2:0] bytes_seen;
  logic [2:0] bytes_seen_next;
  logic       middle_held;
  logic       middle_held_next;
  logic [7:0] pkt [5];

  logic       accept;
  logic       gap;
  logic       emit;
  logic       pkt_we;
  logic [2:0] pkt_sel;
  logic [7:0] pkt_data;
  logic [2:0] bs;
  logic [7:0] dx8;
  logic [7:0] dy8;
  logic [2:0] tmap;

  assign byte_in.ready = q_space;
  assign accept = byte_in.valid && q_space;
  assign push = accept && emit;

  always_comb begin
    gap = byte_in.elapsed_ms > cfg.gap_limit_ms;
    bs = bytes_seen;
    bytes_seen_next = bytes_seen;
    middle_held_next = middle_held;
    emit = 1'b0;
    pkt_we = 1'b0;
    pkt_sel = bytes_seen;
    pkt_data = byte_in.rx_byte;
    dx8 = '0;
    dy8 = '0;
    tmap = three_byte_map(pkt[0][5:4]);
    cmd = '0;
    cmd.time_ms = byte_in.time_ms;
    unique case (cfg.protocol)
      PROTO_THREE: begin
        if (gap || bytes_seen > 3'd3) begin
          bs = 3'd0;
        end
        if (bs == 3'd3 && (byte_in.rx_byte == MIDDLE_UP_BYTE ||
                           byte_in.rx_byte == MIDDLE_DOWN_BYTE)) begin
          // middle-button byte: no motion, swap middle into held buttons
          bytes_seen_next = 3'd0;
          middle_held_next = byte_in.rx_byte[5];
          emit = 1'b1;
          cmd.hold = 1'b1;
          cmd.buttons = {3'b000, byte_in.rx_byte[5], 1'b0};
        end else begin
          if (bs == 3'd3) begin
            bs = 3'd0;
          end
          pkt_we = 1'b1;
          pkt_sel = bs;
          bytes_seen_next = 3'(bs + 3'd1);
          if (bs == 3'd2) begin
            emit = 1'b1;
            dx8 = {pkt[0][1:0], pkt[1][5:0]};
            dy8 = {pkt[0][3:2], byte_in.rx_byte[5:0]};
            cmd.dx = DELTA_W'(signed'(dx8));
            cmd.dy = DELTA_W'(signed'(dy8));
            cmd.buttons = {2'b00, tmap[2], middle_held, tmap[0]};
          end
        end
      end
      PROTO_WHEEL: begin
        if (gap || bytes_seen > 3'd3) begin
          bs = 3'd0;
        end
        pkt_we = 1'b1;
        pkt_sel = bs;
        pkt_data = {1'b0, byte_in.rx_byte[6:0]};
        bytes_seen_next = 3'(bs + 3'd1);
        if (bs == 3'd3) begin
          bytes_seen_next = 3'd0;
          emit = 1'b1;
          dx8 = {1'b0, pkt[1][6:0]} | {pkt[0][1:0], 6'b000000};
          dy8 = {1'b0, pkt[2][6:0]} | {pkt[0][3:2], 6'b000000};
          cmd.dx = DELTA_W'(signed'(dx8));
          cmd.dy = DELTA_W'(signed'(dy8));
          cmd.buttons = {byte_in.rx_byte[3:0] == SCROLL_DOWN_NIB,
                         byte_in.rx_byte[3:0] == SCROLL_UP_NIB,
                         pkt[0][4], byte_in.rx_byte[4], pkt[0][5]};
        end
      end
      PROTO_SYNC: begin
        // a sync header byte always restarts framing
        if (gap || byte_in.rx_byte[7:4] == SYNC_HEAD_NIB || bytes_seen > 3'd4) begin
          bs = 3'd0;
        end
        pkt_we = 1'b1;
        pkt_sel = bs;
        bytes_seen_next = 3'(bs + 3'd1);
        if (bs == 3'd4) begin
          bytes_seen_next = 3'd0;
          emit = 1'b1;
          cmd.dx = DELTA_W'(signed'(pkt[1])) + DELTA_W'(signed'(pkt[3]));
          cmd.dy = -(DELTA_W'(signed'(pkt[2])) + DELTA_W'(signed'(byte_in.rx_byte)));
          cmd.buttons = {2'b00, sync_map(~pkt[0][2:0])};
        end
      end
      default: begin
        // unused protocol code: drop the byte
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && pkt_we) begin
      pkt[pkt_sel] <= pkt_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= 3'd0;
      middle_held <= 1'b0;
    end else if (proto_wr) begin
      bytes_seen <= 3'd0;
    end else if (accept) begin
      bytes_seen <= bytes_seen_next;
      middle_held <= middle_held_next;
    end
  end

  a_bytes_seen_range: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= 3'd4)
    else $error("framing count out of range");

  a_proto_clears: assert property (@(posedge clk) disable iff (rst)
    proto_wr |=> bytes_seen == 3'd0)
    else $error("protocol write did not restart framing");

endmodule

`default_nettype wire

FILE: hdl/smpt_queue.sv
`default_nettype none

module smpt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smpt_pkg::cmd_t  cmd_in,
  output logic            space,
  input  logic            pop,
  output logic            valid,
  output smpt_pkg::cmd_t  cmd_out
);
  import smpt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign space = count != FULL;
  assign valid = count != '0;
  assign cmd_out = entry[rd_ptr];
  assign do_push = push && space;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("queue count above depth");

  a_push_no_drop: assert property (@(posedge clk) disable iff (rst)
    (push && !space) |-> 1'b0)
    else $error("push into full queue");

endmodule

`default_nettype wire

FILE: hdl/smpt_back.sv
`default_nettype none

module smpt_back #(
  parameter int COORD_WIDTH = smpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  smpt_pkg::back_cfg_t  cfg,
  input  logic                 q_valid,
  input  smpt_pkg::cmd_t       q_cmd,
  output logic                 q_pop,
  smpt_event_if.source         event_out
);
  import smpt_pkg::*;

  localparam int SW = ((COORD_WIDTH > SHAPED_W) ? COORD_WIDTH : SHAPED_W) + 1;
  localparam logic signed [SW-1:0] CMIN =
    {{(SW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};
  localparam logic signed [SW-1:0] CMAX =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};

  function automatic logic signed [SHAPED_W-1:0] shape(
    input logic signed [DELTA_W-1:0] d,
    input logic [7:0] level
  );
    logic [DELTA_W-1:0] neg_d;
    logic [8:0]         mag;
    logic [7:0]         gain;
    logic [16:0]        m;
    logic signed [SHAPED_W-1:0] r;
    neg_d = -d;
    mag = d[DELTA_W-1] ? neg_d[8:0] : d[8:0];
    gain = (level < 8'd3) ? 8'd2 : level;
    if (mag == 9'd4) begin
      m = 17'd6 + 17'(level >> 2);
    end else if (mag == 9'd5) begin
      m = 17'd9 + 17'(level >> 1);
    end else if (mag >= 9'd6) begin
      m = mag * gain;
    end else begin
      m = 17'(mag);
    end
    r = d[DELTA_W-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    if (level == 8'd0) begin
      r = SHAPED_W'(d);
    end
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] clamp_axis(
    input logic signed [SW-1:0] v,
    input logic signed [15:0]   lo_raw,
    input logic signed [15:0]   hi_raw
  );
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi_m1;
    logic signed [SW-1:0] r;
    lo = SW'(lo_raw);
    hi_m1 = SW'(hi_raw) - SW'(1);
    r = v;
    // minimum first, so an empty range settles on max - 1
    if (r < lo) begin
      r = lo;
    end
    if (r > hi_m1) begin
      r = hi_m1;
    end
    if (r < CMIN) begin
      r = CMIN;
    end
    if (r > CMAX) begin
      r = CMAX;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  // shaping stage
  logic                       s1_valid;
  logic signed [SHAPED_W-1:0] s1_dx;
  logic signed [SHAPED_W-1:0] s1_dy;
  logic [4:0]                 s1_buttons;
  logic                       s1_hold;
  logic [31:0]                s1_time;
  logic                       s1_move;

  // kept state
  logic signed [COORD_WIDTH-1:0] pointer_x;
  logic signed [COORD_WIDTH-1:0] pointer_y;
  logic [4:0]                    button_state;

  logic signed [COORD_WIDTH-1:0] pointer_x_next;
  logic signed [COORD_WIDTH-1:0] pointer_y_next;
  logic signed [SW-1:0]          wide_x;
  logic signed [SW-1:0]          wide_y;
  logic [4:0]                    buttons_next;

  // output register
  logic               out_valid;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic [4:0]         out_buttons;
  logic [31:0]        out_time;
  logic               out_changed;

  assign s1_move = s1_valid && (!out_valid || event_out.ready);
  assign q_pop = q_valid && (!s1_valid || s1_move);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_move) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_dx <= shape(q_cmd.dx, cfg.acceleration);
      s1_dy <= shape(q_cmd.dy, cfg.acceleration);
      s1_buttons <= q_cmd.buttons;
      s1_hold <= q_cmd.hold;
      s1_time <= q_cmd.time_ms;
    end
  end

  always_comb begin
    pointer_x_next = clamp_axis(SW'(pointer_x) + SW'(s1_dx), cfg.clip_min_x, cfg.clip_max_x);
    pointer_y_next = clamp_axis(SW'(pointer_y) + SW'(s1_dy), cfg.clip_min_y, cfg.clip_max_y);
    wide_x = SW'(pointer_x_next);
    wide_y = SW'(pointer_y_next);
    buttons_next = s1_hold ? ((button_state & 5'b11101) | {3'b000, s1_buttons[1], 1'b0})
                           : s1_buttons;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_x <= '0;
      pointer_y <= '0;
      button_state <= '0;
      out_valid <= 1'b0;
    end else begin
      if (s1_move) begin
        pointer_x <= pointer_x_next;
        pointer_y <= pointer_y_next;
        button_state <= buttons_next;
        out_valid <= 1'b1;
      end else if (event_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_x <= wide_x[15:0];
      out_y <= wide_y[15:0];
      out_buttons <= buttons_next;
      out_time <= s1_time;
      out_changed <= buttons_next != button_state;
    end
  end

  assign event_out.valid = out_valid;
  assign event_out.pos_x = out_x;
  assign event_out.pos_y = out_y;
  assign event_out.button_bits = out_buttons;
  assign event_out.event_time = out_time;
  assign event_out.buttons_changed = out_changed;

  a_hold_pointer: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_out.ready) |=> ($stable(pointer_x) && $stable(pointer_y)))
    else $error("pointer moved while result stalled");

  a_changed_flag: assert property (@(posedge clk) disable iff (rst)
    s1_move |=> (out_changed == (out_buttons != $past(button_state))))
    else $error("button change flag mismatch");

endmodule

`default_nettype wire

FILE: hdl/serial_mouse_packet_tracker_unit.sv
// Path: a byte that completes a packet is written into a queue entry at its transfer,
//   then passes the shaping register, then the position and output register.
// Throughput: one byte per cycle while the queue has space; pointer add and clamp are
//   combinational, so packets complete back to back; a 2-entry queue absorbs output stalls.
// Reset (rst, synchronous): framing, middle button, pointer and buttons clear to zero,
//   registers return to their defaults; stored packet bytes keep whatever they held.
`default_nettype none

module serial_mouse_packet_tracker_unit #(
  parameter int COORD_WIDTH = smpt_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  smpt_byte_if.sink                        byte_in,
  smpt_event_if.source                     event_out,
  input  logic                             wr_en,
  input  logic [smpt_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [smpt_pkg::REG_DATA_W-1:0]  wr_data
);
  import smpt_pkg::*;

  // configuration registers
  proto_t             protocol;
  logic [7:0]         acceleration;
  logic signed [15:0] clip_min_x;
  logic signed [15:0] clip_max_x;
  logic signed [15:0] clip_min_y;
  logic signed [15:0] clip_max_y;
  logic [15:0]        gap_limit_ms;

  logic       proto_wr;
  front_cfg_t front_cfg;
  back_cfg_t  back_cfg;

  // front to queue
  logic push;
  cmd_t push_cmd;
  logic q_space;

  // queue to back
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // A protocol write also restarts framing in the front.
  assign proto_wr = wr_en && (wr_index == REG_PROTOCOL);

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol <= PROTO_THREE;
      acceleration <= '0;
      clip_min_x <= '0;
      clip_max_x <= CLIP_MAX_X_RST;
      clip_min_y <= '0;
      clip_max_y <= CLIP_MAX_Y_RST;
      gap_limit_ms <= GAP_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PROTOCOL:   protocol <= proto_t'(wr_data[1:0]);
        REG_ACCEL:      acceleration <= wr_data[7:0];
        REG_CLIP_MIN_X: clip_min_x <= wr_data;
        REG_CLIP_MAX_X: clip_max_x <= wr_data;
        REG_CLIP_MIN_Y: clip_min_y <= wr_data;
        REG_CLIP_MAX_Y: clip_max_y <= wr_data;
        REG_GAP_LIMIT:  gap_limit_ms <= wr_data;
        default: begin
          // index past the register list: drop the write
          protocol <= protocol;
        end
      endcase
    end
  end

  always_comb begin
    front_cfg.protocol = protocol;
    front_cfg.gap_limit_ms = gap_limit_ms;
    back_cfg.acceleration = acceleration;
    back_cfg.clip_min_x = clip_min_x;
    back_cfg.clip_max_x = clip_max_x;
    back_cfg.clip_min_y = clip_min_y;
    back_cfg.clip_max_y = clip_max_y;
  end

  // Front: frame bytes, decode a finished packet into deltas and buttons.
  smpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (front_cfg),
    .proto_wr (proto_wr),
    .byte_in  (byte_in),
    .q_space  (q_space),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue: hold decoded packets so input keeps flowing while the output stalls.
  smpt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .space   (q_space),
    .pop     (q_pop),
    .valid   (q_valid),
    .cmd_out (q_cmd)
  );

  // Back: shape, advance the pointer, clamp, and register the event.
  smpt_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (back_cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .event_out (event_out)
  );

endmodule

`default_nettype wire

FILE: tb/mouse_event_check.sv
`timescale 1ns / 100ps

module mouse_event_check
  import smpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  smpt_byte_if                  byte_ch,
  smpt_event_if                 event_ch,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [REG_DATA_W-1:0] wr_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam int COORD_LO = -(1 << (COORD_WIDTH_DEF - 1));
  localparam int COORD_HI = (1 << (COORD_WIDTH_DEF - 1)) - 1;

  localparam int BTN_LEFT = 0;
  localparam int BTN_MIDDLE = 1;
  localparam int BTN_RIGHT = 2;
  localparam int BTN_SCROLL_UP = 3;
  localparam int BTN_SCROLL_DOWN = 4;

  // left/right pair of the three-byte header to button bits
  localparam logic [2:0] LR_TO_BUTTONS [4] = '{3'd0, 3'd4, 3'd1, 3'd5};
  // inverted sync-format button field to button bits
  localparam logic [2:0] SYNC_TO_BUTTONS [8] = '{3'd0, 3'd4, 3'd2, 3'd6,
                                                 3'd1, 3'd5, 3'd3, 3'd7};

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [4:0]         buttons;
    logic [31:0]        stamp;
    logic               changed;
  } motion_event_t;

  motion_event_t pending_events[$];

  proto_t             protocol_r;
  logic [7:0]         accel_r;
  logic signed [15:0] min_x, max_x, min_y, max_y;
  logic [15:0]        gap_limit_r;

  logic [2:0]         seen;
  logic [7:0]         frame [5];
  logic               middle_held;
  int                 ptr_x, ptr_y;
  logic [4:0]         held_buttons;
  int                 mismatches = 0;

  function automatic int as_signed_byte(logic [7:0] v);
    return int'(signed'(v));
  endfunction

  function automatic int accel_curve(int d);
    int mag, gain;
    mag = (d < 0) ? -d : d;
    gain = (accel_r < 3) ? 2 : int'(accel_r);
    if (mag == 4)
      mag = 6 + int'(accel_r >> 2);
    else if (mag == 5)
      mag = 9 + int'(accel_r >> 1);
    else if (mag >= 6)
      mag = mag * gain;
    return (d < 0) ? -mag : mag;
  endfunction

  // Minimum first, then maximum, then the coordinate range
  function automatic int clip_axis(int v, logic signed [15:0] lo, logic signed [15:0] hi);
    if (v < int'(lo)) v = int'(lo);
    if (v >= int'(hi)) v = int'(hi) - 1;
    if (v < COORD_LO) v = COORD_LO;
    if (v > COORD_HI) v = COORD_HI;
    return v;
  endfunction

  function automatic void move_pointer(int dx, int dy, logic [4:0] b, logic [31:0] t);
    motion_event_t e;
    if (accel_r != 0) begin
      dx = accel_curve(dx);
      dy = accel_curve(dy);
    end
    ptr_x = clip_axis(ptr_x + dx, min_x, max_x);
    ptr_y = clip_axis(ptr_y + dy, min_y, max_y);
    e.pos_x = ptr_x[15:0];
    e.pos_y = ptr_y[15:0];
    e.buttons = b;
    e.stamp = t;
    e.changed = (b != held_buttons);
    held_buttons = b;
    pending_events.push_back(e);
  endfunction

  function automatic void frame_byte(logic [7:0] c, logic [15:0] el, logic [31:0] t);
    logic       gap;
    logic [3:0] nib;
    logic [4:0] b;
    logic [2:0] sync_idx;
    gap = (el > gap_limit_r);
    case (protocol_r)
      PROTO_THREE: begin
        if (gap || seen > 3) seen = '0;
        if (seen == 3) begin
          seen = '0;
          // middle-button byte: no motion, replace middle only
          if (c == MIDDLE_UP_BYTE || c == MIDDLE_DOWN_BYTE) begin
            middle_held = c[5];
            b = held_buttons;
            b[BTN_MIDDLE] = middle_held;
            move_pointer(0, 0, b, t);
            return;
          end
        end
        frame[seen] = c;
        seen++;
        if (seen == 3) begin
          b = {2'b00, LR_TO_BUTTONS[frame[0][5:4]]};
          b[BTN_MIDDLE] = b[BTN_MIDDLE] | middle_held;
          move_pointer(as_signed_byte({frame[0][1:0], frame[1][5:0]}),
                       as_signed_byte({frame[0][3:2], frame[2][5:0]}), b, t);
        end
      end
      PROTO_WHEEL: begin
        if (gap || seen > 3) seen = '0;
        frame[seen] = c & 8'h7f;
        seen++;
        if (seen == 4) begin
          seen = '0;
          b = '0;
          b[BTN_RIGHT] = frame[0][4];
          b[BTN_LEFT] = frame[0][5];
          b[BTN_MIDDLE] = frame[3][4];
          nib = frame[3][3:0];
          if (nib == SCROLL_UP_NIB)
            b[BTN_SCROLL_UP] = 1'b1;
          else if (nib == SCROLL_DOWN_NIB)
            b[BTN_SCROLL_DOWN] = 1'b1;
          move_pointer(as_signed_byte(frame[1] | {frame[0][1:0], 6'b0}),
                       as_signed_byte(frame[2] | {frame[0][3:2], 6'b0}), b, t);
        end
      end
      PROTO_SYNC: begin
        if (gap || c[7:4] == SYNC_HEAD_NIB || seen > 4) seen = '0;
        frame[seen] = c;
        seen++;
        if (seen == 5) begin
          seen = '0;
          sync_idx = ~frame[0][2:0];
          move_pointer(as_signed_byte(frame[1]) + as_signed_byte(frame[3]),
                       -(as_signed_byte(frame[2]) + as_signed_byte(frame[4])),
                       {2'b00, SYNC_TO_BUTTONS[sync_idx]}, t);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] d);
    case (idx)
      REG_PROTOCOL: begin
        protocol_r = proto_t'(d[1:0]);
        seen = '0;
      end
      REG_ACCEL:      accel_r = d[7:0];
      REG_CLIP_MIN_X: min_x = d;
      REG_CLIP_MAX_X: max_x = d;
      REG_CLIP_MIN_Y: min_y = d;
      REG_CLIP_MAX_Y: max_y = d;
      REG_GAP_LIMIT:  gap_limit_r = d;
      default: ;
    endcase
  endfunction

  function automatic void check_event();
    motion_event_t want;
    if (pending_events.size() == 0) begin
      mismatches++;
      $display("%0t: event with none expected: got x=%0d y=%0d b=%b t=%0d c=%b",
               $time, event_ch.pos_x, event_ch.pos_y, event_ch.button_bits,
               event_ch.event_time, event_ch.buttons_changed);
      return;
    end
    want = pending_events.pop_front();
    if (want.pos_x !== event_ch.pos_x || want.pos_y !== event_ch.pos_y ||
        want.buttons !== event_ch.button_bits || want.stamp !== event_ch.event_time ||
        want.changed !== event_ch.buttons_changed) begin
      mismatches++;
      $display("%0t: mismatch exp x=%0d y=%0d b=%b t=%0d c=%b got x=%0d y=%0d b=%b t=%0d c=%b",
               $time, want.pos_x, want.pos_y, want.buttons, want.stamp, want.changed,
               event_ch.pos_x, event_ch.pos_y, event_ch.button_bits,
               event_ch.event_time, event_ch.buttons_changed);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      protocol_r = PROTO_THREE;
      accel_r = '0;
      min_x = '0;
      max_x = CLIP_MAX_X_RST;
      min_y = '0;
      max_y = CLIP_MAX_Y_RST;
      gap_limit_r = GAP_LIMIT_RST;
      seen = '0;
      middle_held = 1'b0;
      ptr_x = 0;
      ptr_y = 0;
      held_buttons = '0;
      pending_events.delete();
    end else begin
      if (event_ch.valid && event_ch.ready) check_event();
      if (wr_en) write_reg(wr_index, wr_data);
      if (byte_ch.valid && byte_ch.ready)
        frame_byte(byte_ch.rx_byte, byte_ch.elapsed_ms, byte_ch.time_ms);
    end
    fail_count <= mismatches;
    outstanding <= pending_events.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import smpt_pkg::*;

  // Generous bound: ~1000 bytes, each with a random idle on the sender and a random
  // stall on the receiver, plus the pauses between phases.
  localparam int RUN_LIMIT = 200000;
  localparam int PHASE_BYTES = 105;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [REG_DATA_W-1:0] wr_data;

  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  bit          calm = 1'b0;
  logic [15:0] gap_now = GAP_LIMIT_RST;

  smpt_byte_if  byte_ch ();
  smpt_event_if event_ch ();

  serial_mouse_packet_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .event_out (event_ch),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  mouse_event_check tracker_check (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (byte_ch),
    .event_ch    (event_ch),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Event receiver: stall a random number of cycles before each transfer,
  // none at all while the calm stretch is on.
  initial begin : event_drain
    int stall;
    event_ch.ready = 1'b0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        event_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      event_ch.ready <= 1'b1;
      @(posedge clk);
      while (!event_ch.valid) @(posedge clk);
    end
  end

  // Small deltas half of the time so the curve's 4 and 5 steps get hit
  function automatic logic [7:0] pick_delta();
    if ($urandom_range(0, 1) == 0)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 16) - 8);
  endfunction

  // Sync payload byte; keep the header nibble out except now and then
  function automatic logic [7:0] pick_sync_payload();
    logic [7:0] v;
    v = pick_delta();
    if ($urandom_range(0, 29) != 0)
      while (v[7:4] == SYNC_HEAD_NIB) v = pick_delta();
    return v;
  endfunction

  function automatic logic [15:0] ok_gap();
    return 16'($urandom_range(0, gap_now));
  endfunction

  function automatic logic [15:0] late_gap();
    if (gap_now == 16'hffff) return 16'hffff;
    return 16'($urandom_range(gap_now + 1, 65535));
  endfunction

  // Present one byte after a random idle and hold it until the transfer
  task automatic send_byte(input logic [7:0] c, input logic [15:0] el,
                           input logic [31:0] t);
    int idle;
    idle = calm ? 0 : $urandom_range(0, 9);
    if (idle != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.rx_byte <= c;
    byte_ch.elapsed_ms <= el;
    byte_ch.time_ms <= t;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
    // flip into or out of a stretch without idling now and then
    if ($urandom_range(0, 39) == 0) calm = !calm;
  endtask

  // Drop valid, wait out every pending event, then let the pipeline empty
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] d);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= d;
    @(posedge clk);
  endtask

  task automatic program_regs(input proto_t p, input logic [7:0] accel,
                              input logic signed [15:0] x_lo, input logic signed [15:0] x_hi,
                              input logic signed [15:0] y_lo, input logic signed [15:0] y_hi,
                              input logic [15:0] gap_limit);
    put_reg(REG_PROTOCOL, {14'b0, p});
    put_reg(REG_ACCEL, {8'b0, accel});
    put_reg(REG_CLIP_MIN_X, x_lo);
    put_reg(REG_CLIP_MAX_X, x_hi);
    put_reg(REG_CLIP_MIN_Y, y_lo);
    put_reg(REG_CLIP_MAX_Y, y_hi);
    put_reg(REG_GAP_LIMIT, gap_limit);
    wr_en <= 1'b0;
    gap_now = gap_limit;
  endtask

  // One well-formed packet with random content; a late byte in the middle
  // occasionally breaks it.
  task automatic send_packet(input proto_t p);
    logic [7:0]  dx, dy;
    logic [7:0]  pkt [5];
    logic [3:0]  nib;
    logic [31:0] r;
    logic [15:0] el;
    int          len;
    r = $urandom;
    dx = pick_delta();
    dy = pick_delta();
    case (p)
      PROTO_THREE: begin
        pkt[0] = {2'b01, r[1:0], dy[7:6], dx[7:6]};
        pkt[1] = {2'b00, dx[5:0]};
        pkt[2] = {2'b00, dy[5:0]};
        pkt[3] = r[2] ? MIDDLE_DOWN_BYTE : MIDDLE_UP_BYTE;
        len = r[3] ? 4 : 3;
      end
      PROTO_WHEEL: begin
        case (r[9:8])
          2'd0: nib = SCROLL_UP_NIB;
          2'd1: nib = SCROLL_DOWN_NIB;
          default: nib = r[13:10];
        endcase
        pkt[0] = {r[5], 1'b1, r[1:0], dy[7:6], dx[7:6]};
        pkt[1] = {r[6], 1'b0, dx[5:0]};
        pkt[2] = {r[7], 1'b0, dy[5:0]};
        pkt[3] = {r[16:14], r[17], nib};
        len = 4;
      end
      default: begin
        pkt[0] = {SYNC_HEAD_NIB, r[3], r[2:0]};
        for (int i = 1; i < 5; i++) pkt[i] = pick_sync_payload();
        len = 5;
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (i == 0)
        el = r[18] ? 16'($urandom) : ok_gap();
      else
        el = ($urandom_range(0, 24) == 0) ? late_gap() : ok_gap();
      send_byte(pkt[i], el, $urandom);
    end
  endtask

  // Hold the bus idle, load a register set, then run packets mixed with noise
  task automatic run_phase(input proto_t p, input logic [7:0] accel,
                           input logic signed [15:0] x_lo, input logic signed [15:0] x_hi,
                           input logic signed [15:0] y_lo, input logic signed [15:0] y_hi,
                           input logic [15:0] gap_limit);
    int stop_at;
    settle();
    program_regs(p, accel, x_lo, x_hi, y_lo, y_hi, gap_limit);
    stop_at = bytes_sent + PHASE_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 14) == 0)
        send_byte(8'($urandom), 16'($urandom), $urandom);
      else
        send_packet(p);
    end
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    byte_ch.valid = 1'b0;
    byte_ch.rx_byte = '0;
    byte_ch.elapsed_ms = '0;
    byte_ch.time_ms = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Three-byte format at reset settings: both buttons with -1/-1 clamped at
    // the corner, then the middle byte pressing middle.
    send_byte(8'h7f, 16'hffff, 32'h0);
    send_byte(8'h3f, 16'h0, 32'h1);
    send_byte(8'h3f, 16'h0, 32'hffffffff);
    send_byte(MIDDLE_DOWN_BYTE, 16'h0, 32'h2);
    // half a packet, then a gap just over the limit restarts framing
    send_byte(8'h4c, 16'h0, 32'h3);
    send_byte(8'h05, 16'h0, 32'h4);
    send_byte(8'h4c, GAP_LIMIT_RST + 16'd1, 32'h5);
    send_byte(8'h01, GAP_LIMIT_RST, 32'h6);
    send_byte(8'h01, 16'h0, 32'h7);
    send_byte(MIDDLE_UP_BYTE, 16'h0, 32'h8);

    // Unused protocol value: bytes are swallowed with no event
    settle();
    program_regs(PROTO_NONE, 8'd0, 16'sd0, CLIP_MAX_X_RST, 16'sd0, CLIP_MAX_Y_RST,
                 GAP_LIMIT_RST);
    send_byte(8'h40, 16'h0, 32'h9);
    send_byte(8'h00, 16'h0, 32'ha);
    send_byte(8'h00, 16'h0, 32'hb);

    // Wheel format at the lowest stepped gain: |d| of 4 and 5, then 6;
    // scroll up with middle, then scroll down with bit 7 set on the bytes.
    settle();
    program_regs(PROTO_WHEEL, 8'd3, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                 16'hffff);
    send_byte(8'h30, 16'h0, 32'h10);
    send_byte(8'h04, 16'h0, 32'h11);
    send_byte(8'h05, 16'h0, 32'h12);
    send_byte(8'h1f, 16'h0, 32'h13);
    send_byte(8'hc0, 16'h0, 32'h14);
    send_byte(8'h06, 16'h0, 32'h15);
    send_byte(8'h86, 16'h0, 32'h16);
    send_byte(8'h81, 16'h0, 32'h17);

    // Sync format at full gain: largest deltas saturate the pointer; a header
    // byte in the middle of a packet restarts it.
    settle();
    program_regs(PROTO_SYNC, 8'd255, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                 16'hffff);
    send_byte(8'h80, 16'h0, 32'h20);
    send_byte(8'h7f, 16'h0, 32'h21);
    send_byte(8'h7f, 16'h0, 32'h22);
    send_byte(8'h7f, 16'h0, 32'h23);
    send_byte(8'h7f, 16'h0, 32'h24);
    send_byte(8'h87, 16'h0, 32'h25);
    send_byte(8'h81, 16'h0, 32'h26);
    send_byte(8'h01, 16'h0, 32'h27);
    send_byte(8'hff, 16'h0, 32'h28);
    send_byte(8'h01, 16'h0, 32'h29);
    send_byte(8'hff, 16'h0, 32'h2a);

    // Random phases: each protocol several times, gains and clip windows at
    // their extremes, an inverted and an empty window, gap limits 0 and max.
    run_phase(PROTO_THREE, 8'd0, 16'sd0, 16'sd1024, 16'sd0, 16'sd768, 16'd500);
    run_phase(PROTO_WHEEL, 8'd1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
              16'hffff);
    run_phase(PROTO_SYNC, 8'd255, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
              16'd1000);
    run_phase(PROTO_THREE, 8'd3, -16'sd20, 16'sd20, -16'sd5, 16'sd7, 16'd0);
    run_phase(PROTO_SYNC, 8'd2, 16'sd32767, -16'sd32768, 16'sd100, 16'sd50, 16'd300);
    run_phase(PROTO_WHEEL, 8'd200, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
              16'd20);
    run_phase(PROTO_THREE, 8'd255, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
              16'hffff);
    run_phase(PROTO_SYNC, 8'd0, -16'sd1000, 16'sd1000, -16'sd1000, 16'sd1000, 16'd500);
    run_phase(PROTO_WHEEL, 8'd0, 16'sd0, 16'sd1024, 16'sd0, 16'sd768, 16'd500);

    // Drain the last events and give stray ones time to show up
    settle();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/smpt_pkg.sv
hdl/smpt_if.sv
hdl/smpt_front.sv
hdl/smpt_queue.sv
hdl/smpt_back.sv
hdl/serial_mouse_packet_tracker_unit.sv
tb/mouse_event_check.sv
tb/testbench.sv
